[rtl/core/hpsv_pkg.sv]
// Shared constants for the host/port string validator.
// Character codes, port limits and register reset values; no dependencies.
`default_nettype none

package hpsv_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned PortW = 17;
  localparam int unsigned PortMulW = 20;

  localparam logic [CharW-1:0] LengthReset = 8'd253;
  localparam logic [CountW-1:0] CountMax = 8'd255;

  localparam logic [CharW-1:0] ChNul = 8'h00;
  localparam logic [CharW-1:0] ChDash = 8'h2D;
  localparam logic [CharW-1:0] ChDot = 8'h2E;
  localparam logic [CharW-1:0] ChUnder = 8'h5F;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChZero = 8'h30;
  localparam logic [CharW-1:0] ChNine = 8'h39;
  localparam logic [CharW-1:0] ChLowA = 8'h61;
  localparam logic [CharW-1:0] ChLowZ = 8'h7A;
  localparam logic [CharW-1:0] CaseBit = 8'h20;

  localparam logic [PortW-1:0] PortLimit = 17'd65535;
  localparam logic [PortW-1:0] PortSat = 17'd65536;

  localparam logic [1:0] TokNone = 2'd0;
  localparam logic [1:0] TokHost = 2'd1;
  localparam logic [1:0] TokPort = 2'd2;
  localparam logic [1:0] TokExtra = 2'd3;

endpackage

`default_nettype wire

[rtl/core/host_port_string_validator.sv]
// Host name with optional port validator, one byte per word.
// A terminating zero byte gives its result word in the cycle after acceptance.
// Throughput: one byte per cycle; a new byte is taken while a result waits only if
// the output register is being emptied in the same cycle.
// The per-byte state registers and the result register form the only pipeline stage.
// Reset (rst_n, synchronous, active low) clears all string state and sets max_length to 253.
// Depends on hpsv_pkg.
`default_nettype none

module host_port_string_validator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_valid_res,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  // Configuration register.
  logic [7:0] max_length_r;

  // Per-string state.
  logic [hpsv_pkg::CountW-1:0] char_count_r, char_count_nxt;
  logic                        letter_seen_r, letter_seen_nxt;
  logic                        last_was_dash_r, last_was_dash_nxt;
  logic                        inside_token_r, inside_token_nxt;
  logic [1:0]                  token_number_r, token_number_nxt;
  logic                        host_char_bad_r, host_char_bad_nxt;
  logic                        port_char_bad_r, port_char_bad_nxt;
  logic [hpsv_pkg::PortW-1:0]  port_value_r, port_value_nxt;

  // Result register.
  logic out_valid_r, out_valid_nxt;
  logic out_res_r, out_res_nxt;

  logic in_fire;
  logic is_term, is_colon, is_digit, is_letter, is_host_ok;
  logic [7:0] lower_c;
  logic [hpsv_pkg::PortMulW-1:0] port_mul;
  logic ok;

  // Accept whenever the result slot is free or is being drained this cycle.
  assign in_ready      = !out_valid_r || out_ready;
  assign in_fire       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

  // Byte classification; fold case so one range test covers both letter cases.
  assign lower_c   = in_char_byte | hpsv_pkg::CaseBit;
  assign is_term   = (in_char_byte == hpsv_pkg::ChNul);
  assign is_colon  = (in_char_byte == hpsv_pkg::ChColon);
  assign is_letter = (lower_c >= hpsv_pkg::ChLowA) && (lower_c <= hpsv_pkg::ChLowZ);
  assign is_digit  = (in_char_byte >= hpsv_pkg::ChZero) && (in_char_byte <= hpsv_pkg::ChNine);
  assign is_host_ok = is_letter || is_digit || (in_char_byte == hpsv_pkg::ChDot) ||
                      (in_char_byte == hpsv_pkg::ChDash) ||
                      (in_char_byte == hpsv_pkg::ChUnder);

  // Port accumulator: value*10 + digit, computed wide enough for the saturated value.
  assign port_mul = {port_value_r, 3'b000} + {2'b00, port_value_r, 1'b0} +
                    {12'd0, in_char_byte - hpsv_pkg::ChZero};

  // Verdict for a terminating byte, from the state before it.
  always_comb begin
    ok = 1'b1;
    if ((char_count_r == '0) || (char_count_r > max_length_r)) ok = 1'b0;
    if (last_was_dash_r || !letter_seen_r) ok = 1'b0;
    if ((token_number_r == hpsv_pkg::TokExtra) || host_char_bad_r) ok = 1'b0;
    if ((token_number_r == hpsv_pkg::TokPort) &&
        (port_char_bad_r || (port_value_r == '0) || (port_value_r > hpsv_pkg::PortLimit)))
      ok = 1'b0;
  end

  always_comb begin
    char_count_nxt    = char_count_r;
    letter_seen_nxt   = letter_seen_r;
    last_was_dash_nxt = last_was_dash_r;
    inside_token_nxt  = inside_token_r;
    token_number_nxt  = token_number_r;
    host_char_bad_nxt = host_char_bad_r;
    port_char_bad_nxt = port_char_bad_r;
    port_value_nxt    = port_value_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_res_nxt       = out_res_r;

    if (in_fire) begin
      if (is_term) begin
        // Emit the verdict and clear for the next string.
        out_valid_nxt     = 1'b1;
        out_res_nxt       = ok;
        char_count_nxt    = '0;
        letter_seen_nxt   = 1'b0;
        last_was_dash_nxt = 1'b0;
        inside_token_nxt  = 1'b0;
        token_number_nxt  = hpsv_pkg::TokNone;
        host_char_bad_nxt = 1'b0;
        port_char_bad_nxt = 1'b0;
        port_value_nxt    = '0;
      end else begin
        if (char_count_r != hpsv_pkg::CountMax) char_count_nxt = char_count_r + 1'b1;
        if (is_letter) letter_seen_nxt = 1'b1;
        last_was_dash_nxt = (in_char_byte == hpsv_pkg::ChDash);

        if (is_colon) begin
          inside_token_nxt = 1'b0;
        end else begin
          // Open a new token on the first byte of the string and on the first byte after a colon run.
          inside_token_nxt = 1'b1;
          if (!inside_token_r && (token_number_r != hpsv_pkg::TokExtra))
            token_number_nxt = token_number_r + 1'b1;

          if (token_number_nxt == hpsv_pkg::TokHost) begin
            if (!is_host_ok) host_char_bad_nxt = 1'b1;
          end else if (token_number_nxt == hpsv_pkg::TokPort) begin
            if (!is_digit) begin
              port_char_bad_nxt = 1'b1;
            end else if (port_mul > {3'b000, hpsv_pkg::PortSat}) begin
              port_value_nxt = hpsv_pkg::PortSat;
            end else begin
              port_value_nxt = port_mul[hpsv_pkg::PortW-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r    <= hpsv_pkg::LengthReset;
      char_count_r    <= '0;
      letter_seen_r   <= 1'b0;
      last_was_dash_r <= 1'b0;
      inside_token_r  <= 1'b0;
      token_number_r  <= hpsv_pkg::TokNone;
      host_char_bad_r <= 1'b0;
      port_char_bad_r <= 1'b0;
      port_value_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) max_length_r <= cfg_wr_data;
      char_count_r    <= char_count_nxt;
      letter_seen_r   <= letter_seen_nxt;
      last_was_dash_r <= last_was_dash_nxt;
      inside_token_r  <= inside_token_nxt;
      token_number_r  <= token_number_nxt;
      host_char_bad_r <= host_char_bad_nxt;
      port_char_bad_r <= port_char_bad_nxt;
      port_value_r    <= port_value_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

`ifndef SYNTHESIS
  a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_term) |=> (out_valid_r && char_count_r == '0))
    else $error("terminator did not produce a result or clear state");

  a_port_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    port_value_r <= hpsv_pkg::PortSat)
    else $error("port accumulator above saturation value");

  a_empty_no_tokens: assert property (@(posedge clk) disable iff (!rst_n)
    (char_count_r == '0) |-> (token_number_r == hpsv_pkg::TokNone && !letter_seen_r))
    else $error("token or letter state set with no bytes counted");

  a_port_only_in_port_token: assert property (@(posedge clk) disable iff (!rst_n)
    (token_number_r == hpsv_pkg::TokNone || token_number_r == hpsv_pkg::TokHost) |->
      (port_value_r == '0 && !port_char_bad_r))
    else $error("port state changed before the port token");

  a_no_result_from_nonterm: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !(in_fire && is_term)) |=> !out_valid_r)
    else $error("result appeared without a terminator");
`endif

endmodule

`default_nettype wire

[dv/hpsv_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the host/port string validator: follows accepted bytes and
// max_length writes, predicts each verdict and compares the result words.
// Depends on hpsv_pkg.
module hpsv_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_valid_res,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output int         fail_count,
  output int         verdicts_owed
);

  logic [hpsv_pkg::CharW-1:0]  len_limit = hpsv_pkg::LengthReset;
  logic [hpsv_pkg::CountW-1:0] seen_len;
  logic                        saw_letter;
  logic                        dash_last;
  logic                        in_token;
  logic [1:0]                  tok_idx;
  logic                        host_bad;
  logic                        port_bad;
  logic [hpsv_pkg::PortW-1:0]  port_acc;
  logic                        verdict_q[$];
  int                          errs = 0;
  int                          owed = 0;

  assign fail_count    = errs;
  assign verdicts_owed = owed;

  function automatic logic is_alpha(logic [7:0] c);
    return ((c | hpsv_pkg::CaseBit) >= hpsv_pkg::ChLowA) &&
           ((c | hpsv_pkg::CaseBit) <= hpsv_pkg::ChLowZ);
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return (c >= hpsv_pkg::ChZero) && (c <= hpsv_pkg::ChNine);
  endfunction

  task automatic clear_string();
    seen_len   = '0;
    saw_letter = 1'b0;
    dash_last  = 1'b0;
    in_token   = 1'b0;
    tok_idx    = hpsv_pkg::TokNone;
    host_bad   = 1'b0;
    port_bad   = 1'b0;
    port_acc   = '0;
  endtask

  // Fold one byte into the string state; a NUL closes the string.
  task automatic take_char(input logic [7:0] c);
    logic                          ok;
    logic [hpsv_pkg::PortMulW-1:0] next_acc;
    if (c == hpsv_pkg::ChNul) begin
      ok = 1'b1;
      if (seen_len == '0 || seen_len > len_limit) ok = 1'b0;
      if (dash_last || !saw_letter) ok = 1'b0;
      if (tok_idx == hpsv_pkg::TokExtra || host_bad) ok = 1'b0;
      if (tok_idx == hpsv_pkg::TokPort &&
          (port_bad || port_acc == '0 || port_acc > hpsv_pkg::PortLimit))
        ok = 1'b0;
      verdict_q.push_back(ok);
      clear_string();
    end else begin
      if (seen_len != hpsv_pkg::CountMax) seen_len++;
      if (is_alpha(c)) saw_letter = 1'b1;
      dash_last = (c == hpsv_pkg::ChDash);
      if (c == hpsv_pkg::ChColon) begin
        in_token = 1'b0;
      end else begin
        if (!in_token) begin
          in_token = 1'b1;
          if (tok_idx != hpsv_pkg::TokExtra) tok_idx++;
        end
        if (tok_idx == hpsv_pkg::TokHost) begin
          if (!(is_alpha(c) || is_num(c) || c == hpsv_pkg::ChDot ||
                c == hpsv_pkg::ChDash || c == hpsv_pkg::ChUnder))
            host_bad = 1'b1;
        end else if (tok_idx == hpsv_pkg::TokPort) begin
          if (!is_num(c)) begin
            port_bad = 1'b1;
          end else begin
            next_acc = hpsv_pkg::PortMulW'(port_acc) * hpsv_pkg::PortMulW'(10) +
                       hpsv_pkg::PortMulW'(c - hpsv_pkg::ChZero);
            port_acc = (next_acc > hpsv_pkg::PortMulW'(hpsv_pkg::PortSat)) ?
                       hpsv_pkg::PortSat : next_acc[hpsv_pkg::PortW-1:0];
          end
        end
      end
    end
  endtask

  initial clear_string();

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      len_limit = hpsv_pkg::LengthReset;
      clear_string();
      verdict_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result word with none owed, expected none, got valid_res=%0b",
                   $time, out_valid_res);
          errs++;
        end else begin
          want = verdict_q.pop_front();
          if (out_valid_res !== want) begin
            $display("%0t: valid_res mismatch, expected %0b, got %0b",
                     $time, want, out_valid_res);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) take_char(in_char_byte);
      if (cfg_wr_en) len_limit = cfg_wr_data;
    end
    owed = verdict_q.size();
  end

endmodule

[dv/tb_host_port_string_validator.sv]
`timescale 1ns / 100ps
// Top of the host/port string validator testbench: clock, reset, byte stimulus,
// max_length writes and the verdict. Depends on hpsv_pkg, hpsv_checker and the RTL.
module tb_host_port_string_validator;

  localparam int CycleLimit  = 200000;
  localparam int PhaseBudget = 30;   // least bytes queued per phase (60 more in phase 0) before the next setting
  localparam int NumPhases   = 8;

  typedef enum int {RxOpen, RxCoinFlip, RxPeriodic, RxChoked} rx_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_valid_res;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  int         fail_count;
  int         verdicts_owed;
  int         cycles = 0;

  // Bytes of the current phase, NUL terminators included.
  logic [7:0] tx_bytes[$];

  host_port_string_validator uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_valid_res(out_valid_res),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  hpsv_checker scb (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_valid_res(out_valid_res),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .verdicts_owed(verdicts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: switch between stall patterns at random so that
  // back-pressure lands on every phase of the byte stream, open stretches included.
  initial begin
    rx_mode_t mode;
    int       left;
    int       tick;
    mode = RxOpen;
    left = 0;
    tick = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      left--;
      tick++;
      case (mode)
        RxOpen:     out_ready <= 1'b1;
        RxCoinFlip: out_ready <= 1'($urandom_range(0, 1));
        RxPeriodic: out_ready <= (tick % 5) < 3;
        default:    out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Random host character: mostly letters, then digits and the three marks.
  function automatic logic [7:0] host_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return hpsv_pkg::ChLowA + 8'($urandom_range(0, 25));
    if (r < 5) return (hpsv_pkg::ChLowA & ~hpsv_pkg::CaseBit) + 8'($urandom_range(0, 25));
    if (r < 7) return hpsv_pkg::ChZero + 8'($urandom_range(0, 9));
    if (r == 7) return hpsv_pkg::ChDot;
    if (r == 8) return hpsv_pkg::ChDash;
    return hpsv_pkg::ChUnder;
  endfunction

  function automatic logic [7:0] any_letter();
    return ($urandom_range(0, 1) ? hpsv_pkg::ChLowA
                                 : (hpsv_pkg::ChLowA & ~hpsv_pkg::CaseBit)) +
           8'($urandom_range(0, 25));
  endfunction

  // Host token of n bytes; start and end on a letter so it passes on its own.
  task automatic put_host(input int n);
    for (int i = 0; i < n; i++)
      tx_bytes.push_back((i == 0 || i == n - 1) ? any_letter() : host_char());
  endtask

  task automatic put_colons();
    repeat ($urandom_range(1, 3)) tx_bytes.push_back(hpsv_pkg::ChColon);
  endtask

  // Decimal digits of v, optionally behind leading zeros.
  task automatic put_number(input int v, input int zeros);
    logic [7:0] digs[$];
    int         rest;
    rest = v;
    do begin
      digs.push_front(hpsv_pkg::ChZero + 8'(rest % 10));
      rest = rest / 10;
    end while (rest > 0);
    repeat (zeros) tx_bytes.push_back(hpsv_pkg::ChZero);
    foreach (digs[i]) tx_bytes.push_back(digs[i]);
  endtask

  // Port value biased to the edges: zero, one, the top value and just past it.
  task automatic put_port();
    int r;
    int v;
    r = $urandom_range(0, 9);
    case (r)
      0:       v = 0;
      1:       v = 1;
      2:       v = 65535;
      3:       v = 65536;
      4:       v = $urandom_range(65537, 99999999);
      default: v = $urandom_range(1, 65535);
    endcase
    put_number(v, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
  endtask

  task automatic put_literal(input string s);
    foreach (s[i]) tx_bytes.push_back(s[i]);
    tx_bytes.push_back(hpsv_pkg::ChNul);
  endtask

  // One random string, NUL included. Most are well formed host[:port] with
  // random content; the rest break one rule each or are plain noise.
  task automatic add_string();
    int kind;
    int start;
    kind = $urandom_range(0, 11);
    start = tx_bytes.size();
    case (kind)
      0, 1, 2, 3, 4, 5: begin
        put_host($urandom_range(1, 12));
        if ($urandom_range(0, 2) != 0) begin
          put_colons();
          put_port();
        end
        if ($urandom_range(0, 5) == 0) put_colons();
      end
      6: begin
        // a third token
        put_host($urandom_range(1, 6));
        put_colons();
        put_port();
        put_colons();
        put_host($urandom_range(1, 4));
      end
      7: begin
        // port with a stray byte in it
        put_host($urandom_range(1, 6));
        tx_bytes.push_back(hpsv_pkg::ChColon);
        put_number($urandom_range(0, 999), 0);
        tx_bytes.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 1)) put_number($urandom_range(0, 99), 0);
      end
      8: begin
        // one byte of a host overwritten with anything
        put_host($urandom_range(2, 10));
        tx_bytes[start + $urandom_range(0, tx_bytes.size() - start - 1)] =
          8'($urandom_range(1, 255));
      end
      9: begin
        repeat ($urandom_range(0, 8)) tx_bytes.push_back(8'($urandom_range(1, 255)));
      end
      10: begin
        if ($urandom_range(0, 1)) begin
          put_host($urandom_range(1, 8));
          tx_bytes.push_back(hpsv_pkg::ChDash);
        end else begin
          put_number($urandom_range(0, 999), 0);
          tx_bytes.push_back(hpsv_pkg::ChDot);
          put_number($urandom_range(0, 99), 0);
        end
      end
      default: begin
        // leading colons: the host still counts as the first token
        put_colons();
        put_host($urandom_range(1, 8));
        if ($urandom_range(0, 1)) begin
          put_colons();
          put_port();
        end
      end
    endcase
    tx_bytes.push_back(hpsv_pkg::ChNul);
  endtask

  // Feed tx_bytes in bursts. A burst ends with in_valid dropped; now
  // and then the gap lasts until every owed verdict has come back.
  task automatic send_stream();
    int burst_left;
    burst_left = $urandom_range(1, 12);
    foreach (tx_bytes[i]) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        @(negedge clk);
        if ($urandom_range(0, 15) == 0) begin
          while (verdicts_owed != 0) @(negedge clk);
        end else begin
          repeat ($urandom_range(0, 5)) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                 : $urandom_range(1, 12);
      end
      in_valid     <= 1'b1;
      in_char_byte <= tx_bytes[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  // Drain owed verdicts, then let the byte pipeline settle.
  task automatic wait_drained();
    while (verdicts_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int limits[NumPhases];
    int near;
    // Phase 0 runs on the reset value; the others cover both extremes of the
    // field, the saturating 255, the reject-all 0 and a random small limit.
    limits = '{253, 1, 254, 255, 0, 0, 20, 253};
    limits[5] = $urandom_range(2, 60);

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_byte = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        wait_drained();
        write_limit(8'(limits[p]));
      end
      tx_bytes.delete();
      if (p == 0) begin
        // empty, bare letter, trailing dash, no letter at all
        put_literal("");
        put_literal("a");
        put_literal("a-");
        put_literal("12.34");
        // port edges, leading zeros, colon runs, trailing colon, third token
        put_literal("Ab_c.d-Z:0080");
        put_literal("h:65535");
        put_literal("h:65536");
        put_literal("h:0");
        put_literal("h::1");
        put_literal("h:1:");
        put_literal("h:1:2");
        put_literal("h:8x");
        put_literal("h!");
        // bytes above 127 are neither letters nor digits
        tx_bytes.push_back(hpsv_pkg::ChLowA);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(hpsv_pkg::ChNul);
        tx_bytes.push_back(8'h80);
        put_literal("b");
      end
      // Strings right around the limit; past 255 the count saturates.
      if (limits[p] >= 254 || (limits[p] > 0 && limits[p] <= 64)) begin
        near = limits[p] + $urandom_range(0, 3) - 1;
        if (near < 1) near = 1;
        put_host(near);
        tx_bytes.push_back(hpsv_pkg::ChNul);
      end
      while (tx_bytes.size() < PhaseBudget * (p + 1) / (p + 1) + (p == 0 ? 60 : 0) ||
             tx_bytes.size() < PhaseBudget)
        add_string();
      send_stream();
    end

    wait_drained();
    repeat (6) @(negedge clk);
    if (fail_count == 0 && verdicts_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
